// ===== rtl/mbr_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the
// MBR partition table parser. No dependencies.
package mbr_pkg;

  // Sector layout
  localparam int SECTOR_BYTES = 512;
  localparam int TABLE_BASE   = 446;
  localparam int ENTRY_BYTES  = 16;
  localparam int ENTRY_COUNT  = 4;
  localparam int IDX_W        = 2;

  // Field offsets inside one 16-byte table entry
  localparam logic [3:0] OFF_STATUS = 4'd0;
  localparam logic [3:0] OFF_TYPE   = 4'd4;

  // Signature and partition type values
  localparam logic [15:0] BOOT_SIGNATURE = 16'hAA55;
  localparam logic [7:0]  STATUS_MASK    = 8'h7F;
  localparam logic [7:0]  TYPE_EMPTY     = 8'h00;
  localparam logic [7:0]  TYPE_EXT_CHS   = 8'h05;
  localparam logic [7:0]  TYPE_EXT_LBA   = 8'h0F;
  localparam logic [7:0]  TYPE_EXT_LINUX = 8'h85;
  localparam logic [7:0]  TYPE_GPT_PROT  = 8'hEE;

  // Record kinds
  typedef enum logic {
    REC_PART  = 1'b0,
    REC_FINAL = 1'b1
  } rec_kind_t;

  // Final status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SIG    = 2'd1,
    ST_BAD_STATUS = 2'd2,
    ST_GPT        = 2'd3
  } status_code_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic         take;       // input word accepted this cycle
    logic         idx_clr;    // restart entry walk at entry 0
    logic         idx_inc;    // advance to next entry
    logic         rec_load;   // load output record register
    rec_kind_t    rec_kind;
    status_code_t rec_code;
    logic         rec_entry;  // record names the current entry
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic at_last;      // current word is the last byte of the sector
    logic sig_ok;       // captured signature matches
    logic ent_invalid;  // current entry has reserved status bits set
    logic ent_skip;     // current entry is empty or extended
    logic ent_gpt;      // current entry is protective GPT
    logic idx_last;     // current entry is the last one
    logic out_free;     // output register can take a record this cycle
  } dp_status_t;

endpackage

// ===== rtl/mbr_if.sv =====
// Valid/ready channel interfaces for sector bytes and parsed records.
// Depends on nothing beyond the field widths of the parser.
interface mbr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] sector_byte;
  logic       start_of_sector;

  modport source (output valid, output sector_byte, output start_of_sector, input ready);
  modport sink (input valid, input sector_byte, input start_of_sector, output ready);
endinterface

interface mbr_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [1:0]  entry_index;
  logic [7:0]  part_type;
  logic [31:0] first_lba;
  logic [31:0] sector_count;
  logic [1:0]  status_code;
  logic        last;

  modport source (
    output valid, output record_kind, output entry_index, output part_type,
    output first_lba, output sector_count, output status_code, output last,
    input ready
  );
  modport sink (
    input valid, input record_kind, input entry_index, input part_type,
    input first_lba, input sector_count, input status_code, input last,
    output ready
  );
endinterface

// ===== rtl/mbr_dp.sv =====
// Datapath: byte position, entry table capture, signature, entry walk index
// and output record register. Depends on mbr_pkg and mbr_if.
module mbr_dp #(
  parameter int SECTOR_BYTES = mbr_pkg::SECTOR_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  mbr_byte_if.sink            bytes,
  mbr_rec_if.source           records,
  input  mbr_pkg::ctrl_cmd_t  cmd,
  output mbr_pkg::dp_status_t sts
);

  localparam int POS_W     = $clog2(SECTOR_BYTES);
  localparam int TABLE_END = mbr_pkg::TABLE_BASE + mbr_pkg::ENTRY_BYTES * mbr_pkg::ENTRY_COUNT;

  logic [POS_W-1:0]          pos;
  logic [POS_W-1:0]          eff_pos;
  logic [POS_W-1:0]          rel;
  logic                      in_table;
  logic [mbr_pkg::IDX_W-1:0] wr_ent;
  logic [3:0]                wr_off;

  logic [7:0]  ent_status [mbr_pkg::ENTRY_COUNT];
  logic [7:0]  ent_type   [mbr_pkg::ENTRY_COUNT];
  logic [31:0] ent_lba    [mbr_pkg::ENTRY_COUNT];
  logic [31:0] ent_len    [mbr_pkg::ENTRY_COUNT];
  logic [7:0]  sig_low;
  logic [7:0]  sig_high;

  logic [mbr_pkg::IDX_W-1:0] idx;
  logic [7:0]                cur_status;
  logic [7:0]                cur_type;

  logic        out_valid;
  logic        out_kind;
  logic [1:0]  out_index;
  logic [7:0]  out_type;
  logic [31:0] out_lba;
  logic [31:0] out_count;
  logic [1:0]  out_code;

  // Decode the position of the current word
  assign eff_pos  = bytes.start_of_sector ? '0 : pos;
  assign rel      = eff_pos - POS_W'(mbr_pkg::TABLE_BASE);
  assign in_table = (eff_pos >= POS_W'(mbr_pkg::TABLE_BASE)) &&
                    (eff_pos < POS_W'(TABLE_END));
  assign wr_ent   = rel[5:4];
  assign wr_off   = rel[3:0];

  // Advance the byte position, wrapping after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.take) begin
      pos <= (eff_pos == POS_W'(SECTOR_BYTES - 1)) ? '0 : eff_pos + 1'b1;
    end
  end

  // Capture table fields and signature bytes
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (in_table) begin
        if (wr_off == mbr_pkg::OFF_STATUS) begin
          ent_status[wr_ent] <= bytes.sector_byte;
        end else if (wr_off == mbr_pkg::OFF_TYPE) begin
          ent_type[wr_ent] <= bytes.sector_byte;
        end else if (wr_off[3:2] == 2'b10) begin
          ent_lba[wr_ent][{wr_off[1:0], 3'b000} +: 8] <= bytes.sector_byte;
        end else if (wr_off[3:2] == 2'b11) begin
          ent_len[wr_ent][{wr_off[1:0], 3'b000} +: 8] <= bytes.sector_byte;
        end
      end else if (eff_pos == POS_W'(SECTOR_BYTES - 2)) begin
        sig_low <= bytes.sector_byte;
      end else if (eff_pos == POS_W'(SECTOR_BYTES - 1)) begin
        sig_high <= bytes.sector_byte;
      end
    end
  end

  // Step the entry walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Classify the current entry
  assign cur_status = ent_status[idx];
  assign cur_type   = ent_type[idx];

  assign sts.at_last     = (eff_pos == POS_W'(SECTOR_BYTES - 1));
  assign sts.sig_ok      = ({sig_high, sig_low} == mbr_pkg::BOOT_SIGNATURE);
  assign sts.ent_invalid = |(cur_status & mbr_pkg::STATUS_MASK);
  assign sts.ent_skip    = (cur_type == mbr_pkg::TYPE_EMPTY)   ||
                           (cur_type == mbr_pkg::TYPE_EXT_CHS) ||
                           (cur_type == mbr_pkg::TYPE_EXT_LBA) ||
                           (cur_type == mbr_pkg::TYPE_EXT_LINUX);
  assign sts.ent_gpt     = (cur_type == mbr_pkg::TYPE_GPT_PROT);
  assign sts.idx_last    = (idx == mbr_pkg::IDX_W'(mbr_pkg::ENTRY_COUNT - 1));
  assign sts.out_free    = !out_valid || records.ready;

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rec_load) begin
      out_valid <= 1'b1;
    end else if (records.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output record payload
  always_ff @(posedge clk) begin
    if (cmd.rec_load) begin
      out_kind  <= cmd.rec_kind;
      out_code  <= cmd.rec_code;
      out_index <= cmd.rec_entry ? idx : '0;
      out_type  <= cmd.rec_entry ? cur_type : '0;
      out_lba   <= (cmd.rec_kind == mbr_pkg::REC_PART) ? ent_lba[idx] : '0;
      out_count <= (cmd.rec_kind == mbr_pkg::REC_PART) ? ent_len[idx] : '0;
    end
  end

  assign records.valid        = out_valid;
  assign records.record_kind  = out_kind;
  assign records.entry_index  = out_index;
  assign records.part_type    = out_type;
  assign records.first_lba    = out_lba;
  assign records.sector_count = out_count;
  assign records.status_code  = out_code;
  assign records.last         = (out_kind == mbr_pkg::REC_FINAL);

  // A partition record always carries an ok code
  a_part_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == mbr_pkg::REC_PART) |-> (out_code == mbr_pkg::ST_OK))
    else $error("partition record with non-ok status");

  // Never overwrite a record that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.rec_load |-> (!out_valid || records.ready))
    else $error("output record overwritten");

endmodule

// ===== rtl/mbr_ctrl.sv =====
// Controller: receives sector bytes, checks the signature, then walks the four entries one per
// cycle unless held for a free output register, and issues record loads. Depends on mbr_pkg.
module mbr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbr_pkg::dp_status_t sts,
  output mbr_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_RECV = 4'b0001,
    S_SIG  = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_RECV);

  // Sequence the receive, signature check and entry walk
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.rec_kind  = mbr_pkg::REC_FINAL;
    cmd.rec_code  = mbr_pkg::ST_OK;
    unique case (state)
      S_RECV: begin
        cmd.take = in_valid;
        if (in_valid && sts.at_last) begin
          state_next = S_SIG;
        end
      end
      S_SIG: begin
        cmd.idx_clr = 1'b1;
        if (sts.sig_ok) begin
          state_next = S_WALK;
        end else if (sts.out_free) begin
          cmd.rec_load = 1'b1;
          cmd.rec_code = mbr_pkg::ST_BAD_SIG;
          state_next   = S_RECV;
        end
      end
      S_WALK: begin
        priority if (sts.ent_invalid) begin
          if (sts.out_free) begin
            cmd.rec_load  = 1'b1;
            cmd.rec_code  = mbr_pkg::ST_BAD_STATUS;
            cmd.rec_entry = 1'b1;
            state_next    = S_RECV;
          end
        end else if (sts.ent_skip) begin
          cmd.idx_inc = !sts.idx_last;
          if (sts.idx_last) begin
            state_next = S_FIN;
          end
        end else if (sts.ent_gpt) begin
          if (sts.out_free) begin
            cmd.rec_load  = 1'b1;
            cmd.rec_code  = mbr_pkg::ST_GPT;
            cmd.rec_entry = 1'b1;
            state_next    = S_RECV;
          end
        end else begin
          if (sts.out_free) begin
            cmd.rec_load  = 1'b1;
            cmd.rec_kind  = mbr_pkg::REC_PART;
            cmd.rec_entry = 1'b1;
            cmd.idx_inc   = !sts.idx_last;
            if (sts.idx_last) begin
              state_next = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.rec_load = 1'b1;
          state_next   = S_RECV;
        end
      end
      default: begin
        state_next = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

  // The last byte of a sector always starts the signature check
  a_last_to_sig: assert property (@(posedge clk) disable iff (rst)
    cmd.take && sts.at_last |=> (state == S_SIG))
    else $error("last byte did not start walk");

  // A final record always ends the walk and reopens the input
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.rec_load && (cmd.rec_kind == mbr_pkg::REC_FINAL) |=> (state == S_RECV))
    else $error("final record did not end walk");

  // The index never advances past the last entry
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.idx_inc |-> !sts.idx_last)
    else $error("entry index overrun");

endmodule

// ===== rtl/mbr_partition_table_parser.sv =====
// MBR partition table parser. Sector bytes are taken one word per cycle;
// bytes 0 to 510 give no record. After byte 511 the input stalls while the
// controller checks the signature and walks up to four table entries
// through a single entry read port, one entry per cycle unless the record
// sink holds ready low, then emits the final status record. The last record
// stays in the output register until taken, also while the next sector
// streams in. Depends on mbr_pkg, mbr_if, mbr_dp and mbr_ctrl.
module mbr_partition_table_parser #(
  parameter int SECTOR_BYTES = mbr_pkg::SECTOR_BYTES
) (
  input  logic      clk,
  input  logic      rst,
  mbr_byte_if.sink  bytes,
  mbr_rec_if.source records
);

  mbr_pkg::ctrl_cmd_t  cmd;
  mbr_pkg::dp_status_t sts;
  logic                in_ready;

  // Hand the controller's ready to the byte channel
  assign bytes.ready = in_ready;

  mbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbr_dp #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes),
    .records (records),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

// ===== dv/mbr_partition_table_parser_tb.sv =====
// Testbench for the MBR partition table parser: streams sector images over the
// byte channel and checks every parsed record against a built-in predictor.
// Depends on mbr_pkg, the mbr_byte_if/mbr_rec_if interfaces and the parser RTL.
module mbr_partition_table_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_NS     = 5;
  localparam int LIMIT_NS    = 5_000_000;
  localparam int LBA_OFF     = 8;
  localparam int CNT_OFF     = 12;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 1200;
  localparam int PHASE_SECTORS = 14;
  localparam int END_WAIT    = 50_000;
  localparam int GRACE       = 32;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    mbr_pkg::rec_kind_t    kind;
    logic [1:0]            idx;
    logic [7:0]            ptype;
    logic [31:0]           lba;
    logic [31:0]           cnt;
    mbr_pkg::status_code_t code;
    logic                  last;
  } part_rec_t;

  // One sector image; the per-entry vectors list entry 3 first
  typedef struct packed {
    logic [3:0][7:0]  status;
    logic [3:0][7:0]  ptype;
    logic [3:0][31:0] lba;
    logic [3:0][31:0] cnt;
    logic [15:0]      sig;
    logic             sos;
    logic             has_final;
    part_rec_t        final_rec;
  } sector_row_t;

  logic clk = 1'b0;
  logic rst;

  mbr_byte_if byte_ch ();
  mbr_rec_if  rec_ch ();

  mbr_partition_table_parser DUT (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .records (rec_ch)
  );

  // Predictor state
  logic [8:0]  sec_pos = '0;
  logic [15:0] ent_st_ty [mbr_pkg::ENTRY_COUNT];
  logic [31:0] ent_lba [mbr_pkg::ENTRY_COUNT];
  logic [31:0] ent_len [mbr_pkg::ENTRY_COUNT];
  logic [7:0]  sig_lo = '0;
  part_rec_t   expected_records [$];

  // Hand-written expectation for the next sector end, armed by the sender
  part_rec_t   typed_final;
  logic        typed_armed = 1'b0;

  int          failures = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  sector_row_t directed_rows [12];

  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  function automatic part_rec_t final_of(input logic [1:0] idx, input logic [7:0] ptype,
                                         input mbr_pkg::status_code_t code);
    return '{mbr_pkg::REC_FINAL, idx, ptype, 32'd0, 32'd0, code, 1'b1};
  endfunction

  function automatic string rec_text(input part_rec_t r);
    return $sformatf("kind=%0d idx=%0d type=%02h lba=%08h cnt=%08h code=%0d last=%0d",
                     r.kind, r.idx, r.ptype, r.lba, r.cnt, r.code, r.last);
  endfunction

  // Walk the captured table on the last byte and queue the records it yields
  function automatic void walk_table(input logic [7:0] sig_hi);
    int e;
    logic [7:0] st;
    logic [7:0] ty;
    if (typed_armed) begin
      expected_records.push_back(typed_final);
      typed_armed = 1'b0;
      return;
    end
    if ({sig_hi, sig_lo} != mbr_pkg::BOOT_SIGNATURE) begin
      expected_records.push_back(final_of(2'd0, 8'h00, mbr_pkg::ST_BAD_SIG));
      return;
    end
    for (e = 0; e < mbr_pkg::ENTRY_COUNT; e++) begin
      st = ent_st_ty[e][7:0];
      ty = ent_st_ty[e][15:8];
      if ((st & mbr_pkg::STATUS_MASK) != 8'h00) begin
        expected_records.push_back(final_of(2'(e), ty, mbr_pkg::ST_BAD_STATUS));
        return;
      end
      if (ty == mbr_pkg::TYPE_EMPTY || ty == mbr_pkg::TYPE_EXT_CHS ||
          ty == mbr_pkg::TYPE_EXT_LBA || ty == mbr_pkg::TYPE_EXT_LINUX) begin
        continue;
      end
      if (ty == mbr_pkg::TYPE_GPT_PROT) begin
        expected_records.push_back(final_of(2'(e), ty, mbr_pkg::ST_GPT));
        return;
      end
      expected_records.push_back('{mbr_pkg::REC_PART, 2'(e), ty, ent_lba[e], ent_len[e],
                                   mbr_pkg::ST_OK, 1'b0});
    end
    expected_records.push_back(final_of(2'd0, 8'h00, mbr_pkg::ST_OK));
  endfunction

  // Track the byte position and capture table and signature bytes
  function automatic void absorb_sector_byte(input logic [7:0] b, input logic sos);
    int rel;
    int e;
    int off;
    if (sos) sec_pos = '0;
    if (sec_pos == mbr_pkg::SECTOR_BYTES - 1) begin
      walk_table(b);
    end else if (sec_pos >= mbr_pkg::TABLE_BASE &&
                 sec_pos < mbr_pkg::TABLE_BASE +
                           mbr_pkg::ENTRY_BYTES * mbr_pkg::ENTRY_COUNT) begin
      rel = sec_pos - mbr_pkg::TABLE_BASE;
      e = rel / mbr_pkg::ENTRY_BYTES;
      off = rel % mbr_pkg::ENTRY_BYTES;
      if (off == mbr_pkg::OFF_STATUS) begin
        ent_st_ty[e][7:0] = b;
      end else if (off == mbr_pkg::OFF_TYPE) begin
        ent_st_ty[e][15:8] = b;
      end else if (off >= LBA_OFF && off < CNT_OFF) begin
        ent_lba[e][8*(off-LBA_OFF) +: 8] = b;
      end else if (off >= CNT_OFF) begin
        ent_len[e][8*(off-CNT_OFF) +: 8] = b;
      end
    end else if (sec_pos == mbr_pkg::SECTOR_BYTES - 2) begin
      sig_lo = b;
    end
    sec_pos = sec_pos + 9'd1;
  endfunction

  function automatic void check_record(input part_rec_t got);
    part_rec_t want;
    if (expected_records.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS) $display("record with none expected: %s", rec_text(got));
      return;
    end
    want = expected_records.pop_front();
    if (got !== want) begin
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("record mismatch: expected %s", rec_text(want));
        $display("                 actual   %s", rec_text(got));
      end
    end
  endfunction

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) begin
        absorb_sector_byte(byte_ch.sector_byte, byte_ch.start_of_sector);
      end
      if (rec_ch.valid && rec_ch.ready) begin
        check_record('{mbr_pkg::rec_kind_t'(rec_ch.record_kind), rec_ch.entry_index,
                       rec_ch.part_type, rec_ch.first_lba, rec_ch.sector_count,
                       mbr_pkg::status_code_t'(rec_ch.status_code), rec_ch.last});
      end
    end
  end

  // Drive record ready; a hold request blocks the sink for a long stretch
  always @(negedge clk) begin
    if (hold_seen != hold_request) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rec_ch.ready <= 1'b0;
    end else begin
      rec_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #LIMIT_NS;
    $display("mbr_partition_table_parser_tb: FAIL");
    $finish;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Build a mostly well-formed table with random content
  function automatic sector_row_t random_row();
    sector_row_t r;
    int e;
    int pick;
    r = '0;
    for (e = 0; e < mbr_pkg::ENTRY_COUNT; e++) begin
      pick = $urandom_range(99);
      if (pick < 45) r.status[e] = 8'h00;
      else if (pick < 85) r.status[e] = 8'h80;
      else r.status[e] = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 10) r.ptype[e] = mbr_pkg::TYPE_EMPTY;
      else if (pick < 16) r.ptype[e] = mbr_pkg::TYPE_EXT_CHS;
      else if (pick < 22) r.ptype[e] = mbr_pkg::TYPE_EXT_LBA;
      else if (pick < 28) r.ptype[e] = mbr_pkg::TYPE_EXT_LINUX;
      else if (pick < 33) r.ptype[e] = mbr_pkg::TYPE_GPT_PROT;
      else r.ptype[e] = 8'($urandom);
      r.lba[e] = pick_word();
      r.cnt[e] = pick_word();
    end
    r.sig = ($urandom_range(99) < 88) ? mbr_pkg::BOOT_SIGNATURE : 16'($urandom);
    r.sos = 1'b1;
    return r;
  endfunction

  // Offer one word after the caller's falling edge; return once it is taken
  task automatic send_word(input logic [7:0] b, input logic sos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.sector_byte <= b;
    byte_ch.start_of_sector <= sos;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // Stream the first nbytes of a sector image built from a row
  task automatic send_sector(input sector_row_t row, input int nbytes);
    logic [7:0] img [mbr_pkg::SECTOR_BYTES];
    int i;
    int e;
    int k;
    int base;
    for (i = 0; i < mbr_pkg::SECTOR_BYTES; i++) img[i] = 8'($urandom);
    for (e = 0; e < mbr_pkg::ENTRY_COUNT; e++) begin
      base = mbr_pkg::TABLE_BASE + e * mbr_pkg::ENTRY_BYTES;
      img[base + mbr_pkg::OFF_STATUS] = row.status[e];
      img[base + mbr_pkg::OFF_TYPE] = row.ptype[e];
      for (k = 0; k < 4; k++) begin
        img[base + LBA_OFF + k] = row.lba[e][8*k +: 8];
        img[base + CNT_OFF + k] = row.cnt[e][8*k +: 8];
      end
    end
    img[mbr_pkg::SECTOR_BYTES-2] = row.sig[7:0];
    img[mbr_pkg::SECTOR_BYTES-1] = row.sig[15:8];
    for (i = 0; i < nbytes; i++) begin
      @(negedge clk);
      // arm a hand-written result at a falling edge, clear of the sampler
      if (i == 0 && row.has_final && nbytes == mbr_pkg::SECTOR_BYTES) begin
        typed_final = row.final_rec;
        typed_armed = 1'b1;
      end
      send_word(img[i], (i == 0) ? row.sos : 1'b0);
    end
  endtask

  // Random words with stray start-of-sector marks
  task automatic send_noise();
    int i;
    for (i = 0; i < mbr_pkg::SECTOR_BYTES; i++) begin
      @(negedge clk);
      send_word(8'($urandom), $urandom_range(49) == 0);
    end
  endtask

  // Drop valid and hold until every queued record has arrived or the limit runs out
  task automatic drain(input int limit);
    int waited;
    waited = 0;
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (expected_records.size() != 0 && waited < limit) begin
      @(negedge clk);
      waited++;
    end
  endtask

  task automatic set_idling(input idle_mode_t mode);
    @(posedge clk);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 49;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 49;
      end
      default: begin
        send_idle_pct = 22;
        recv_stall_pct = 22;
      end
    endcase
  endtask

  initial begin
    sector_row_t row;
    int r;
    int ph;
    int s;
    int pick;
    logic aligned;

    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.sector_byte = 8'h00;
    byte_ch.start_of_sector = 1'b0;
    rec_ch.ready = 1'b0;

    // Entry vectors read entry 3 first; untyped rows go through the predictor
    directed_rows = '{
      // all entries empty, good signature
      '{32'h0, 32'h0, 128'h0, 128'h0, mbr_pkg::BOOT_SIGNATURE, 1'b1, 1'b1,
        final_of(2'd0, 8'h00, mbr_pkg::ST_OK)},
      // byte-swapped signature
      '{32'h0000_0080, 32'h0000_0083, 128'h1, 128'h10, 16'h55AA, 1'b1, 1'b1,
        final_of(2'd0, 8'h00, mbr_pkg::ST_BAD_SIG)},
      // signature one bit off
      '{32'h0, 32'h0000_000C, 128'h2, 128'h20, 16'hAA54, 1'b1, 1'b1,
        final_of(2'd0, 8'h00, mbr_pkg::ST_BAD_SIG)},
      // reserved status bit on the first entry
      '{32'h0000_0001, 32'h0000_0083, 128'h0, 128'h0, mbr_pkg::BOOT_SIGNATURE, 1'b1, 1'b1,
        final_of(2'd0, 8'h83, mbr_pkg::ST_BAD_STATUS)},
      // protective GPT on the first entry
      '{32'h0000_0080, 32'h0000_00EE, 128'h0, 128'h0, mbr_pkg::BOOT_SIGNATURE, 1'b1, 1'b1,
        final_of(2'd0, mbr_pkg::TYPE_GPT_PROT, mbr_pkg::ST_GPT)},
      // bad status wins over GPT type
      '{32'h0000_007F, 32'h0000_00EE, 128'h0, 128'h0, mbr_pkg::BOOT_SIGNATURE, 1'b1, 1'b1,
        final_of(2'd0, mbr_pkg::TYPE_GPT_PROT, mbr_pkg::ST_BAD_STATUS)},
      // four live entries, address and length extremes
      '{32'h8000_0080, 32'hFF0C_0783,
        128'hFFFFFFFF_00000001_80000000_00000000,
        128'h00000000_FFFFFFFF_7FFFFFFF_00000001,
        mbr_pkg::BOOT_SIGNATURE, 1'b1, 1'b0, '0},
      // extended entries skipped
      '{32'h8000_0000, 32'h8385_0F05,
        128'h12345678_0_0_0, 128'h9ABCDEF0_0_0_0, mbr_pkg::BOOT_SIGNATURE, 1'b1, 1'b0, '0},
      // new sector without a start mark, after position wrap
      '{32'h0000_0000, 32'h0100_0007,
        128'h00000800_0_0_00000800, 128'h00001000_0_0_00FFF000,
        mbr_pkg::BOOT_SIGNATURE, 1'b0, 1'b0, '0},
      // bad status on a later entry
      '{32'h00FF_0080, 32'h8383_8383,
        128'h4_3_2_1, 128'h40_30_20_10, mbr_pkg::BOOT_SIGNATURE, 1'b1, 1'b0, '0},
      // protective GPT after live entries
      '{32'h0, 32'hEE00_0B06,
        128'h0_0_00000100_00000080, 128'h0_0_00000200_00000040,
        mbr_pkg::BOOT_SIGNATURE, 1'b1, 1'b0, '0},
      // reserved status bit on the last entry
      '{32'h4000_0000, 32'h8383_0C0C,
        128'h0_DEADBEEF_01020304_A5A5A5A5, 128'h0_CAFEF00D_05060708_5A5A5A5A,
        mbr_pkg::BOOT_SIGNATURE, 1'b1, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed sectors at full rate
    set_idling(IDLE_NONE);
    for (r = 0; r < 12; r++) send_sector(directed_rows[r], mbr_pkg::SECTOR_BYTES);
    drain(END_WAIT);

    // Random sectors under each idling pattern
    aligned = 1'b1;
    for (ph = 0; ph < 4; ph++) begin
      set_idling(idle_mode_t'(ph));
      for (s = 0; s < PHASE_SECTORS; s++) begin
        // stall the sink long enough for the input to back up
        if (ph == 0 && s == 3) hold_request++;
        pick = $urandom_range(99);
        // keep whole sectors under the hold so the output register fills
        if (ph == 0 && (s == 3 || s == 4)) pick = 0;
        if (pick < 80) begin
          row = random_row();
          row.sos = aligned ? 1'($urandom_range(1)) : 1'b1;
          send_sector(row, mbr_pkg::SECTOR_BYTES);
          aligned = 1'b1;
        end else if (pick < 90) begin
          row = random_row();
          send_sector(row, $urandom_range(1, mbr_pkg::SECTOR_BYTES - 2));
          aligned = 1'b0;
        end else begin
          send_noise();
          aligned = 1'b0;
        end
      end
      drain(END_WAIT);
    end

    repeat (GRACE) @(negedge clk);
    if (expected_records.size() != 0) begin
      failures++;
      $display("%0d expected records never arrived", expected_records.size());
    end
    if (failures == 0) begin
      $display("mbr_partition_table_parser_tb: PASS");
    end else begin
      $display("mbr_partition_table_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
